// ===== src/assert_macros.svh =====
// Assertion helpers for the RTL files; poly1305_mac includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define P1305_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check that a condition never holds outside reset.
`define P1305_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    `P1305_ASSERT(lbl, clk, rst_n, !(expr))

`endif

// ===== src/p1305_pkg.sv =====
package p1305_pkg;

    localparam int WORD_W     = 64;
    localparam int LEN_W      = 5;
    localparam int CFG_IDX_W  = 3;

    // Limb widths of the accumulator
    localparam int LIMB_W     = 44;
    localparam int TOP_W      = 42;

    // Shared multiplier: one limb times one half of a coefficient
    localparam int MUL_A_W    = 46;
    localparam int MUL_B_W    = 25;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int COEF_W     = 2 * MUL_B_W;
    localparam int DSUM_W     = 94;

    localparam int NUM_TERMS  = 9;
    localparam int MUL_STEPS  = 2 * NUM_TERMS;
    localparam int STEP_W     = $clog2(MUL_STEPS);
    localparam int FIN_STEPS  = 6;

    // Clamp masks of the r limbs
    localparam logic [43:0] R0_MASK = 44'hFFC_0FFF_FFFF;
    localparam logic [43:0] R1_MASK = 44'hFFF_FFC0_FFFF;
    localparam logic [39:0] R2_MASK = 40'h0F_FFFF_FC0F;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_R_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_R_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_PAD_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_PAD_HIGH = 3'd3;

    typedef enum logic [1:0] {
        LIMB_H0,
        LIMB_H1,
        LIMB_H2
    } t_limb;

    typedef enum logic [2:0] {
        COEF_R0,
        COEF_R1,
        COEF_R2,
        COEF_S1,
        COEF_S2
    } t_coef;

    typedef enum logic [1:0] {
        DSUM_0,
        DSUM_1,
        DSUM_2
    } t_dsel;

    typedef struct packed {
        t_limb a_sel;
        t_coef b_sel;
        t_dsel d_sel;
    } t_term;

    // Tag that travels with a product through the multiplier register
    typedef struct packed {
        t_dsel d_sel;
        logic  upper;
    } t_mul_tag;

    // Product schedule: d0 = h0*r0 + h1*s2 + h2*s1, d1 = h0*r1 + h1*r0 + h2*s2,
    // d2 = h0*r2 + h1*r1 + h2*r0
    function automatic t_term term_of(input logic [STEP_W-2:0] j);
        t_term t;
        unique case (j)
            4'd0:    t = '{LIMB_H0, COEF_R0, DSUM_0};
            4'd1:    t = '{LIMB_H1, COEF_S2, DSUM_0};
            4'd2:    t = '{LIMB_H2, COEF_S1, DSUM_0};
            4'd3:    t = '{LIMB_H0, COEF_R1, DSUM_1};
            4'd4:    t = '{LIMB_H1, COEF_R0, DSUM_1};
            4'd5:    t = '{LIMB_H2, COEF_S2, DSUM_1};
            4'd6:    t = '{LIMB_H0, COEF_R2, DSUM_2};
            4'd7:    t = '{LIMB_H1, COEF_R1, DSUM_2};
            4'd8:    t = '{LIMB_H2, COEF_R0, DSUM_2};
            default: t = '{LIMB_H0, COEF_R0, DSUM_0};
        endcase
        return t;
    endfunction

endpackage

// ===== src/p1305_if.sv =====
interface p1305_in_if;
    import p1305_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] block_low;
    logic [WORD_W-1:0] block_high;
    logic [LEN_W-1:0]  block_len;
    logic              is_last;

    modport source (output valid, output block_low, output block_high,
                    output block_len, output is_last, input ready);
    modport sink   (input valid, input block_low, input block_high,
                    input block_len, input is_last, output ready);
endinterface

interface p1305_out_if;
    import p1305_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] tag_low;
    logic [WORD_W-1:0] tag_high;

    modport source (output valid, output tag_low, output tag_high, input ready);
    modport sink   (input valid, input tag_low, input tag_high, output ready);
endinterface

// ===== src/p1305_pad.sv =====
module p1305_pad (
    input  logic [p1305_pkg::WORD_W-1:0] i_block_low,
    input  logic [p1305_pkg::WORD_W-1:0] i_block_high,
    input  logic [p1305_pkg::LEN_W-1:0]  i_block_len,
    output logic [p1305_pkg::LIMB_W-1:0] o_m0,
    output logic [p1305_pkg::LIMB_W-1:0] o_m1,
    output logic [p1305_pkg::TOP_W-2:0]  o_m2
);
    import p1305_pkg::*;

    logic [2*WORD_W-1:0] raw;
    logic [2*WORD_W-1:0] fmt;
    logic                full;

    assign raw  = {i_block_high, i_block_low};
    // any count of sixteen or more is a full block
    assign full = i_block_len[LEN_W-1];

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            if (full || (LEN_W'(i) < i_block_len)) begin
                fmt[i*8 +: 8] = raw[i*8 +: 8];
            end else if (LEN_W'(i) == i_block_len) begin
                fmt[i*8 +: 8] = 8'h01;
            end else begin
                fmt[i*8 +: 8] = 8'h00;
            end
        end
    end

    assign o_m0 = fmt[43:0];
    assign o_m1 = fmt[87:44];
    assign o_m2 = {full, fmt[127:88]};

endmodule

// ===== src/p1305_mul.sv =====
module p1305_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [p1305_pkg::MUL_A_W-1:0] i_a,
    input  logic [p1305_pkg::MUL_B_W-1:0] i_b,
    input  p1305_pkg::t_mul_tag           i_tag,
    output logic                          o_vld,
    output logic [p1305_pkg::MUL_P_W-1:0] o_prod,
    output p1305_pkg::t_mul_tag           o_tag
);
    import p1305_pkg::*;

    logic               r_vld;
    logic [MUL_P_W-1:0] r_prod;
    t_mul_tag           r_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_start;
        end
        r_prod <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
        r_tag  <= i_tag;
    end

    assign o_vld  = r_vld;
    assign o_prod = r_prod;
    assign o_tag  = r_tag;

endmodule

// ===== src/poly1305_mac.sv =====
// Poly1305 authenticator. Load the 256-bit key as four 64-bit registers (r low,
// r high, pad low, pad high) while the block is idle, then send one 16-byte
// message word per item with its byte count; mark the final word with is_last
// and the 128-bit tag comes out on the result channel. A word with a nonzero
// count runs the accept cycle, 18 passes through one shared 46x25-bit
// multiplier (nine limb products, each split in two halves), a drain cycle
// and four carry steps. A final word adds full reduction and the pad add; a
// final zero-count word goes from the accept cycle straight to those, and a
// non-final one returns to idle. The input is not ready while a word is in work; a
// finished tag waits in its output register without holding up the next message,
// but the next tag stalls in the pad step until that register has been taken.
module poly1305_mac (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    p1305_in_if.sink                        i_blk,
    p1305_out_if.source                     o_tag,
    input  logic                            i_cfg_we,
    input  logic [p1305_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [p1305_pkg::WORD_W-1:0]    i_cfg_data
);
    import p1305_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_DRAIN,
        S_RED0,
        S_RED1,
        S_RED2,
        S_RED3,
        S_FCARRY,
        S_FSEL,
        S_FPAD
    } t_state;

    t_state              r_state;
    logic [STEP_W-1:0]   r_step;
    logic                r_last;
    logic                r_out_vld;
    logic [WORD_W-1:0]   r_tag_lo;
    logic [WORD_W-1:0]   r_tag_hi;

    logic [WORD_W-1:0]   r_key_r_lo;
    logic [WORD_W-1:0]   r_key_r_hi;
    logic [WORD_W-1:0]   r_key_pad_lo;
    logic [WORD_W-1:0]   r_key_pad_hi;

    logic [LIMB_W-1:0]   r_acc0;
    logic [LIMB_W:0]     r_acc1;
    logic [TOP_W-1:0]    r_acc2;

    logic [52:0]         r_h0;
    logic [45:0]         r_h1;
    logic [42:0]         r_h2;
    logic [48:0]         r_s1;
    logic [44:0]         r_s2;
    logic [DSUM_W-1:0]   r_d0;
    logic [DSUM_W-1:0]   r_d1;
    logic [DSUM_W-1:0]   r_d2;

    logic                in_fire;
    logic                out_free;
    logic                tag_emit;
    logic [LIMB_W-1:0]   m0;
    logic [LIMB_W-1:0]   m1;
    logic [TOP_W-2:0]    m2;
    logic [43:0]         kr0;
    logic [43:0]         kr1;
    logic [39:0]         kr2;
    logic [48:0]         n_s1;
    logic [44:0]         n_s2;

    t_term               term;
    logic [MUL_A_W-1:0]  mul_a;
    logic [COEF_W-1:0]   mul_b_full;
    logic [MUL_B_W-1:0]  mul_b;
    t_mul_tag            mul_tag_in;
    logic                mul_vld;
    logic [MUL_P_W-1:0]  mul_prod;
    t_mul_tag            mul_tag;
    logic [95:0]         addend_full;
    logic [DSUM_W-1:0]   addend;

    logic [51:0]         red_c;
    logic [54:0]         red_c5;
    logic [LIMB_W:0]     n_acc1;

    logic [42:0]         fa_h2;
    logic [52:0]         fb_h0;
    logic [45:0]         fc_h1;
    logic [44:0]         sel_s0;
    logic [45:0]         sel_s1;
    logic [42:0]         sel_t;
    logic [44:0]         pad_a0;
    logic [46:0]         pad_a1;
    logic [TOP_W-1:0]    pad_h2;

    assign in_fire  = i_blk.valid && i_blk.ready;
    assign out_free = !r_out_vld || o_tag.ready;
    assign tag_emit = (r_state == S_FPAD) && out_free;

    assign i_blk.ready    = (r_state == S_IDLE);
    assign o_tag.valid    = r_out_vld;
    assign o_tag.tag_low  = r_tag_lo;
    assign o_tag.tag_high = r_tag_hi;

    p1305_pad u_pad (
        .i_block_low  (i_blk.block_low),
        .i_block_high (i_blk.block_high),
        .i_block_len  (i_blk.block_len),
        .o_m0         (m0),
        .o_m1         (m1),
        .o_m2         (m2)
    );

    // Clamped r limbs and the 5*4 multiples that fold the top limbs back in
    assign kr0  = r_key_r_lo[43:0] & R0_MASK;
    assign kr1  = {r_key_r_hi[23:0], r_key_r_lo[63:44]} & R1_MASK;
    assign kr2  = r_key_r_hi[63:24] & R2_MASK;
    assign n_s1 = 49'({kr1, 4'b0000}) + 49'({kr1, 2'b00});
    assign n_s2 = 45'({kr2, 4'b0000}) + 45'({kr2, 2'b00});

    assign term = term_of(r_step[STEP_W-1:1]);

    always_comb begin
        unique case (term.a_sel)
            LIMB_H0: mul_a = r_h0[MUL_A_W-1:0];
            LIMB_H1: mul_a = r_h1;
            LIMB_H2: mul_a = MUL_A_W'(r_h2);
            default: mul_a = '0;
        endcase
        unique case (term.b_sel)
            COEF_R0: mul_b_full = COEF_W'(kr0);
            COEF_R1: mul_b_full = COEF_W'(kr1);
            COEF_R2: mul_b_full = COEF_W'(kr2);
            COEF_S1: mul_b_full = COEF_W'(r_s1);
            COEF_S2: mul_b_full = COEF_W'(r_s2);
            default: mul_b_full = '0;
        endcase
    end

    assign mul_b            = r_step[0] ? mul_b_full[COEF_W-1:MUL_B_W]
                                        : mul_b_full[MUL_B_W-1:0];
    assign mul_tag_in.d_sel = term.d_sel;
    assign mul_tag_in.upper = r_step[0];

    p1305_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_MUL),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_tag   (mul_tag_in),
        .o_vld   (mul_vld),
        .o_prod  (mul_prod),
        .o_tag   (mul_tag)
    );

    assign addend_full = mul_tag.upper ? {mul_prod, 25'd0} : {25'd0, mul_prod};
    assign addend      = addend_full[DSUM_W-1:0];

    // Carry the product sums down into limbs
    assign red_c  = r_d2[DSUM_W-1:42];
    assign red_c5 = 55'({red_c, 2'b00}) + 55'(red_c);
    assign n_acc1 = 45'(r_h1[43:0]) + 45'(r_h0[52:44]);

    // Final reduction: three carry phases run twice, then the compare with p
    assign fa_h2  = r_h2 + 43'(r_h1[45:44]);
    assign fb_h0  = r_h0 + (r_h2[42] ? 53'd5 : 53'd0);
    assign fc_h1  = r_h1 + 46'(r_h0[52:44]);

    assign sel_s0 = 45'(r_h0[43:0]) + 45'd5;
    assign sel_s1 = r_h1 + 46'(sel_s0[44]);
    assign sel_t  = r_h2 + 43'(sel_s1[45:44]);

    assign pad_a0 = 45'(r_h0[43:0]) + 45'(r_key_pad_lo[43:0]);
    assign pad_a1 = 47'(r_h1) + 47'({r_key_pad_hi[23:0], r_key_pad_lo[63:44]})
                  + 47'(pad_a0[44]);
    assign pad_h2 = r_h2[41:0] + 42'(r_key_pad_hi[63:24]) + 42'(pad_a1[46:44]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step       <= '0;
            r_out_vld    <= 1'b0;
            r_key_r_lo   <= '0;
            r_key_r_hi   <= '0;
            r_key_pad_lo <= '0;
            r_key_pad_hi <= '0;
            r_acc0       <= '0;
            r_acc1       <= '0;
            r_acc2       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_KEY_R_LOW:    r_key_r_lo   <= i_cfg_data;
                    CFG_KEY_R_HIGH:   r_key_r_hi   <= i_cfg_data;
                    CFG_KEY_PAD_LOW:  r_key_pad_lo <= i_cfg_data;
                    CFG_KEY_PAD_HIGH: r_key_pad_hi <= i_cfg_data;
                    default: ;
                endcase
            end

            if (tag_emit) begin
                r_out_vld <= 1'b1;
            end else if (o_tag.ready) begin
                r_out_vld <= 1'b0;
            end

            if (mul_vld) begin
                unique case (mul_tag.d_sel)
                    DSUM_0:  r_d0 <= r_d0 + addend;
                    DSUM_1:  r_d1 <= r_d1 + addend;
                    DSUM_2:  r_d2 <= r_d2 + addend;
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_last <= i_blk.is_last;
                        r_s1   <= n_s1;
                        r_s2   <= n_s2;
                        r_step <= '0;
                        if (i_blk.block_len == '0) begin
                            // nothing to absorb
                            r_h0    <= 53'(r_acc0);
                            r_h1    <= 46'(r_acc1);
                            r_h2    <= 43'(r_acc2);
                            r_state <= i_blk.is_last ? S_FCARRY : S_IDLE;
                        end else begin
                            r_h0    <= 53'(r_acc0) + 53'(m0);
                            r_h1    <= 46'(r_acc1) + 46'(m1);
                            r_h2    <= 43'(r_acc2) + 43'(m2);
                            r_d0    <= '0;
                            r_d1    <= '0;
                            r_d2    <= '0;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_RED0;
                end
                S_RED0: begin
                    r_h0    <= 53'(r_d0[43:0]);
                    r_d1    <= r_d1 + DSUM_W'(r_d0[DSUM_W-1:44]);
                    r_state <= S_RED1;
                end
                S_RED1: begin
                    r_h1    <= 46'(r_d1[43:0]);
                    r_d2    <= r_d2 + DSUM_W'(r_d1[DSUM_W-1:44]);
                    r_state <= S_RED2;
                end
                S_RED2: begin
                    r_h2    <= 43'(r_d2[41:0]);
                    r_h0    <= r_h0 + red_c5[52:0];
                    r_state <= S_RED3;
                end
                S_RED3: begin
                    r_acc0  <= r_h0[43:0];
                    r_acc1  <= n_acc1;
                    r_acc2  <= r_h2[41:0];
                    r_h0    <= 53'(r_h0[43:0]);
                    r_h1    <= 46'(n_acc1);
                    r_h2    <= 43'(r_h2[41:0]);
                    r_step  <= '0;
                    r_state <= r_last ? S_FCARRY : S_IDLE;
                end
                S_FCARRY: begin
                    unique case (r_step[2:0])
                        3'd0, 3'd3: begin
                            r_h1 <= 46'(r_h1[43:0]);
                            r_h2 <= fa_h2;
                        end
                        3'd1, 3'd4: begin
                            r_h0 <= fb_h0;
                            r_h2 <= 43'(r_h2[41:0]);
                        end
                        default: begin
                            r_h0 <= 53'(r_h0[43:0]);
                            r_h1 <= fc_h1;
                        end
                    endcase
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(FIN_STEPS - 1)) begin
                        r_state <= S_FSEL;
                    end
                end
                S_FSEL: begin
                    // take h - p when h reaches p
                    if (sel_t[42]) begin
                        r_h0 <= 53'(sel_s0[43:0]);
                        r_h1 <= 46'(sel_s1[43:0]);
                        r_h2 <= 43'(sel_t[41:0]);
                    end
                    r_state <= S_FPAD;
                end
                S_FPAD: begin
                    if (out_free) begin
                        r_tag_lo  <= {pad_a1[19:0], pad_a0[43:0]};
                        r_tag_hi  <= {pad_h2[39:0], pad_a1[43:20]};
                        r_acc0    <= '0;
                        r_acc1    <= '0;
                        r_acc2    <= '0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `P1305_ASSERT(a_mul_step_range, i_clk, i_rst_n,
        (r_state == S_MUL) |-> (r_step < STEP_W'(MUL_STEPS)))
    `P1305_ASSERT_NEVER(a_mul_stray_product, i_clk, i_rst_n,
        mul_vld && (r_state != S_MUL) && (r_state != S_DRAIN))
    `P1305_ASSERT(a_acc_clear_after_tag, i_clk, i_rst_n,
        tag_emit |=> (r_acc0 == '0 && r_acc1 == '0 && r_acc2 == '0))
    `P1305_ASSERT(a_empty_word_skips, i_clk, i_rst_n,
        (in_fire && i_blk.block_len == '0 && !i_blk.is_last) |=> (r_state == S_IDLE))

endmodule
